// ===== src/window_stats_anomaly_scorer_macros.svh =====
// ----------------------------------------------------------------------------
// window_stats_anomaly_scorer_macros.svh
// Assertion shorthands for the anomaly scorer, clocked on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef WINDOW_STATS_ANOMALY_SCORER_MACROS_SVH
`define WINDOW_STATS_ANOMALY_SCORER_MACROS_SVH

// consequent checked in the same cycle
`define WSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsa: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define WSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsa: next-cycle check failed");

`endif

// ===== src/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants of the window statistics anomaly scorer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsa_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACT_W      = 2;
  localparam int PERF_W     = 17;
  localparam int CONF_W     = 17;
  localparam int DIV_STEPS  = 17;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int OUT_DATA_W = 40;

  localparam logic [ACT_W-1:0] ACT_INNOV   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ERR     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ANALYZE = 2'd2;

  // at most one datapath step per cycle, issued by the controller
  typedef struct packed {
    logic take_sample;
    logic upd_innov;
    logic upd_err;
    logic prep;
    logic mul;
    logic load_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic                window_empty;
    logic                suggest_model_review;
    logic                suggest_tuning;
    logic                anomaly;
    logic [CONF_W-1:0]   confidence;
    logic [PERF_W-1:0]   performance;
  } result_t;

endpackage

// ===== src/wsa_div.sv =====
// ----------------------------------------------------------------------------
// wsa_div
// Restoring divider, one quotient bit per step: floor(num * 2^15 / den).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsa_div #(
  parameter int NUM_W = 49
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [NUM_W-1:0]            num,
  input  logic [NUM_W-2:0]            den,
  output logic [wsa_pkg::PERF_W-1:0]  quot
);

  localparam int REM_W = NUM_W + wsa_pkg::PERF_W - 2;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dv;
  logic             fits;

  // quotient is known to stay below 2^17, so the divisor starts at den << 16
  assign fits = rem >= dv;

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= {num, {(wsa_pkg::PERF_W - 2){1'b0}}};
      dv   <= {den, {(wsa_pkg::PERF_W - 1){1'b0}}};
      quot <= '0;
    end else if (step) begin
      if (fits) begin
        rem <= rem - dv;
      end
      dv   <= dv >> 1;
      quot <= {quot[wsa_pkg::PERF_W-2:0], fits};
    end
  end

endmodule

// ===== src/wsa_dp.sv =====
// ----------------------------------------------------------------------------
// wsa_dp
// Datapath: sample rings, running sums, score arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsa_dp #(
  parameter int WINDOW = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wsa_pkg::cmd_t                 cmd,
  input  logic [wsa_pkg::SAMPLE_W-1:0]  sample_in,
  output wsa_pkg::result_t              res
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int HW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW  = wsa_pkg::SAMPLE_W + CW;
  localparam int QW  = 2 * wsa_pkg::SAMPLE_W + CW;
  localparam int AW  = CW + 8;
  localparam int BW  = SW + 1;
  localparam int MW  = AW + BW;
  localparam int NW  = 2 * BW + 1;
  localparam int VW  = 2 * SW;
  localparam int V9W = VW + 4;

  // ---------------------------------------------------------------- sample path
  logic [15:0]      innov_ring [WINDOW];
  logic [15:0]      err_ring   [WINDOW];
  logic [15:0]      innov_old, err_old;
  logic [HW-1:0]    innov_head, err_head;
  logic [CW-1:0]    innov_count, err_count;
  logic [SW-1:0]    innov_sum, err_sum;
  logic [QW-1:0]    innov_sq_sum;
  logic [15:0]      innov_latest;
  logic [15:0]      sample;
  logic [31:0]      sample_sq;
  logic             innov_full, err_full;
  logic [15:0]      innov_drop, err_drop;
  logic [31:0]      innov_drop_sq;
  logic [HW-1:0]    innov_head_next, err_head_next;

  assign innov_full    = innov_count == CW'(WINDOW);
  assign err_full      = err_count == CW'(WINDOW);
  assign innov_drop    = innov_full ? innov_old : 16'd0;
  assign err_drop      = err_full ? err_old : 16'd0;
  assign innov_drop_sq = innov_full ? innov_old * innov_old : 32'd0;
  assign innov_head_next = (innov_head == HW'(WINDOW - 1)) ? '0 : innov_head + 1'b1;
  assign err_head_next   = (err_head == HW'(WINDOW - 1)) ? '0 : err_head + 1'b1;

  // read ports run every cycle; the head does not move between accept and update
  always_ff @(posedge clk) begin
    innov_old <= innov_ring[innov_head];
    if (cmd.upd_innov) begin
      innov_ring[innov_head] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    err_old <= err_ring[err_head];
    if (cmd.upd_err) begin
      err_ring[err_head] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      sample    <= sample_in;
      sample_sq <= sample_in * sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      innov_head   <= '0;
      innov_count  <= '0;
      innov_sum    <= '0;
      innov_sq_sum <= '0;
      innov_latest <= '0;
      err_head     <= '0;
      err_count    <= '0;
      err_sum      <= '0;
    end else begin
      if (cmd.upd_innov) begin
        innov_head   <= innov_head_next;
        innov_count  <= innov_full ? innov_count : innov_count + 1'b1;
        innov_sum    <= innov_sum - SW'(innov_drop) + SW'(sample);
        innov_sq_sum <= innov_sq_sum - QW'(innov_drop_sq) + QW'(sample_sq);
        innov_latest <= sample;
      end
      if (cmd.upd_err) begin
        err_head  <= err_head_next;
        err_count <= err_full ? err_count : err_count + 1'b1;
        err_sum   <= err_sum - SW'(err_drop) + SW'(sample);
      end
    end
  end

  // ---------------------------------------------------------- confidence table
  logic [wsa_pkg::CONF_W-1:0] conf_rom [WINDOW + 1];

  for (genvar gi = 0; gi <= WINDOW; gi++) begin : g_conf
    // truncated series of 1 - exp(-x), x in Q2.30
    localparam logic [63:0] X   = (64'(gi) << 30) / WINDOW;
    localparam logic [63:0] T1  = X;
    localparam logic [63:0] T2  = ((T1 * X) >> 30) / 2;
    localparam logic [63:0] T3  = ((T2 * X) >> 30) / 3;
    localparam logic [63:0] T4  = ((T3 * X) >> 30) / 4;
    localparam logic [63:0] T5  = ((T4 * X) >> 30) / 5;
    localparam logic [63:0] T6  = ((T5 * X) >> 30) / 6;
    localparam logic [63:0] T7  = ((T6 * X) >> 30) / 7;
    localparam logic [63:0] T8  = ((T7 * X) >> 30) / 8;
    localparam logic [63:0] T9  = ((T8 * X) >> 30) / 9;
    localparam logic [63:0] T10 = ((T9 * X) >> 30) / 10;
    localparam logic [63:0] T11 = ((T10 * X) >> 30) / 11;
    localparam logic [63:0] T12 = ((T11 * X) >> 30) / 12;
    localparam logic [63:0] T13 = ((T12 * X) >> 30) / 13;
    localparam logic [63:0] T14 = ((T13 * X) >> 30) / 14;
    localparam logic [63:0] T15 = ((T14 * X) >> 30) / 15;
    localparam logic [63:0] T16 = ((T15 * X) >> 30) / 16;
    localparam logic [63:0] T17 = ((T16 * X) >> 30) / 17;
    localparam logic [63:0] T18 = ((T17 * X) >> 30) / 18;
    localparam logic [63:0] T19 = ((T18 * X) >> 30) / 19;
    localparam logic [63:0] T20 = ((T19 * X) >> 30) / 20;
    localparam logic [63:0] ACC = T1 - T2 + T3 - T4 + T5 - T6 + T7 - T8 + T9 - T10
                                + T11 - T12 + T13 - T14 + T15 - T16 + T17 - T18
                                + T19 - T20;
    localparam logic [63:0] CONF = (ACC + 64'd8192) >> 14;
    assign conf_rom[gi] = CONF[wsa_pkg::CONF_W-1:0];
  end

  // ------------------------------------------------------------- score path
  logic [AW-1:0]  a_i, c_e;
  logic [BW-1:0]  b_i, d_e;
  logic [SW-1:0]  nx;
  logic [VW-1:0]  nq, ssq;
  logic [wsa_pkg::CONF_W-1:0] conf;
  logic           review, empty;
  logic [MW-1:0]  ad, cb;
  logic [2*BW-1:0] bd;
  logic [SW-1:0]  dev;
  logic [VW-1:0]  var_s;
  logic [NW-1:0]  num;
  logic           tuning;
  logic [VW-1:0]  dev2;
  logic [V9W-1:0] var9;
  logic [wsa_pkg::PERF_W-1:0] quot;

  assign a_i = {innov_count, 8'd0};
  assign c_e = {err_count, 8'd0};
  assign num = NW'(ad) + NW'(cb);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      b_i    <= BW'(a_i) + BW'(innov_sum);
      d_e    <= BW'(c_e) + BW'(err_sum);
      nx     <= SW'(innov_count) * SW'(innov_latest);
      nq     <= VW'(innov_count) * VW'(innov_sq_sum);
      ssq    <= VW'(innov_sum) * VW'(innov_sum);
      conf   <= conf_rom[innov_count];
      review <= innov_sum > SW'(a_i);
      empty  <= (innov_count == '0) || (err_count == '0);
    end
    if (cmd.mul) begin
      ad    <= MW'(a_i) * MW'(d_e);
      cb    <= MW'(c_e) * MW'(b_i);
      bd    <= (2 * BW)'(b_i) * (2 * BW)'(d_e);
      dev   <= (nx >= innov_sum) ? nx - innov_sum : innov_sum - nx;
      var_s <= nq - ssq;
    end
    if (cmd.load_div) begin
      tuning <= num < NW'(bd);
      dev2   <= VW'(dev) * VW'(dev);
      var9   <= V9W'({var_s, 3'b000}) + V9W'(var_s);
    end
  end

  wsa_div #(
    .NUM_W (NW)
  ) u_div (
    .clk  (clk),
    .load (cmd.load_div),
    .step (cmd.div_step),
    .num  (num),
    .den  (bd),
    .quot (quot)
  );

  // an empty window zeroes every field but the empty flag
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.window_empty         <= empty;
      res.suggest_model_review <= !empty && review;
      res.suggest_tuning       <= !empty && tuning;
      res.anomaly              <= !empty && (V9W'(dev2) > var9);
      res.confidence           <= empty ? '0 : conf;
      res.performance          <= empty ? '0 : quot;
    end
  end

endmodule

// ===== src/wsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsa_ctrl
// Controller: request handshakes and the step sequence of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic [wsa_pkg::ACT_W-1:0]  s_tuser,
  output logic                       s_tready,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output wsa_pkg::cmd_t              cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD_I = 3'd1;
  localparam logic [2:0] ST_UPD_E = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]                     state, state_next;
  logic [wsa_pkg::DIV_CNT_W-1:0]  div_cnt;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_sample = 1'b1;
          case (s_tuser)
            wsa_pkg::ACT_INNOV:   state_next = ST_UPD_I;
            wsa_pkg::ACT_ERR:     state_next = ST_UPD_E;
            wsa_pkg::ACT_ANALYZE: state_next = ST_PREP;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_UPD_I: begin
        cmd.upd_innov = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_UPD_E: begin
        cmd.upd_err = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.load_div = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == wsa_pkg::DIV_CNT_W'(wsa_pkg::DIV_STEPS - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the result register to drain
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= (state == ST_DIV) ? div_cnt + 1'b1 : '0;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/window_stats_anomaly_scorer.sv =====
// Sample request: the window is updated in the cycle after the accept.
// Analyze request: prep, multiply, sum, 17-step divide and output states, in order.
// Input is ready again after a result is loaded; a held result does not block samples.
// Reset (rst, synchronous) empties both windows; ring contents are not cleared.
// ----------------------------------------------------------------------------
// window_stats_anomaly_scorer
// Sliding-window innovation/error statistics with a 3-sigma anomaly score.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_stats_anomaly_scorer_macros.svh"

module window_stats_anomaly_scorer #(
  parameter int WINDOW = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wsa_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample_value
  input  logic [wsa_pkg::ACT_W-1:0]       s_tuser,   // [1:0] action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [16:0] performance, [33:17] confidence, [34] anomaly, [35] suggest_tuning,
  // [36] suggest_model_review, [39:37] zero
  output logic [wsa_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [0:0]                      m_tuser    // [0] window_empty
);

  wsa_pkg::cmd_t    cmd;
  wsa_pkg::result_t res;

  wsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  wsa_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample_in (s_tdata),
    .res       (res)
  );

  assign m_tdata = {3'b000, res.suggest_model_review, res.suggest_tuning, res.anomaly,
                    res.confidence, res.performance};
  assign m_tuser = res.window_empty;

  `WSA_ASSERT_NOW(a_cmd_single, 1'b1, $onehot0(cmd))
  `WSA_ASSERT_NOW(a_load_out_free, cmd.load_out, !m_tvalid || m_tready)
  `WSA_ASSERT_NEXT(a_analyze_busy, s_tvalid && s_tready && s_tuser == wsa_pkg::ACT_ANALYZE, !s_tready)
  `WSA_ASSERT_NEXT(a_innov_update, s_tvalid && s_tready && s_tuser == wsa_pkg::ACT_INNOV, cmd.upd_innov)

endmodule
